// ===== rtl/sorted_interpolation_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// sorted interpolation table assertion macros
// concurrent check wrappers, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef SORTED_INTERPOLATION_TABLE_UNIT_ASSERT_SVH
`define SORTED_INTERPOLATION_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SIT_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error(msg);
`define SIT_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error(msg);
`else
`define SIT_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define SIT_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// ===== rtl/sit_pkg.sv =====
// ----------------------------------------------------------------------------
// sit_pkg
// shared constants and types of the sorted interpolation table
// ----------------------------------------------------------------------------
`default_nettype none
package sit_pkg;
	localparam int SIT_PAIRS = 8;
	localparam int KEY_W = 20;
	localparam int FAC_W = 24;
	localparam int OP_W = 2;
	localparam int DIFF_W = 25;          // f1 - f0
	localparam int PROD_W = KEY_W + DIFF_W + 1;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// divider control
	typedef struct packed {
		logic                     start;
		logic                     neg;
		logic [PROD_W-1:0]        num;   // magnitude
		logic [KEY_W-1:0]         den;
	} div_req_t;
endpackage
`default_nettype wire

// ===== rtl/sit_div.sv =====
// ----------------------------------------------------------------------------
// sit_div
// restoring divider, one quotient bit per cycle, signed result truncated
// ----------------------------------------------------------------------------
`default_nettype none
module sit_div (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire sit_pkg::div_req_t   req,
	output logic                     done,
	output logic signed [sit_pkg::PROD_W-1:0] quot
);
	import sit_pkg::*;

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic [PROD_W-1:0] q_q;
	logic [KEY_W:0]    rem_q;
	logic [KEY_W-1:0]  den_q;
	logic              neg_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic [KEY_W:0]    trial;
	logic [KEY_W:0]    shifted;

	assign shifted = {rem_q[KEY_W-1:0], q_q[PROD_W-1]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(PROD_W);
				q_q <= req.num;
				rem_q <= '0;
				den_q <= req.den;
				neg_q <= req.neg;
			end else if (busy_q) begin
				if (!trial[KEY_W]) begin
					rem_q <= trial;
					q_q <= {q_q[PROD_W-2:0], 1'b1};
				end else begin
					rem_q <= shifted;
					q_q <= {q_q[PROD_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign quot = neg_q ? -$signed(q_q) : $signed(q_q);
endmodule
`default_nettype wire

// ===== rtl/sorted_interpolation_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_interpolation_table_unit
// sorted (key, factor) table with piecewise-linear interpolating lookup
// ----------------------------------------------------------------------------
// channel  direction  handshake      payload
// in       to block   valid / stall  op, speed_key, factor_in
// out      from block valid / stall  factor_out, pair_count
//
// one request at a time; stall is high from acceptance until the result
// leaves the output register
// lookup: scans the pairs in key order, then runs the serial divide (load, 46-bit
// quotient, finish) when the key lies between two stored keys; insert: moves pairs
// to open a gap; clear and unused ops go straight to the output register
// reset clears count and eviction slot; the stores hold garbage until written
// ----------------------------------------------------------------------------
`default_nettype none
`include "sorted_interpolation_table_unit_assert.svh"
module sorted_interpolation_table_unit #(
	parameter int PAIRS = sit_pkg::SIT_PAIRS
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_stall,
	input  wire  [sit_pkg::OP_W-1:0]      op,
	input  wire  [sit_pkg::KEY_W-1:0]     speed_key,
	input  wire  signed [sit_pkg::FAC_W-1:0] factor_in,
	output logic                          out_valid,
	input  wire                           out_stall,
	output logic signed [sit_pkg::FAC_W-1:0] factor_out,
	output logic [$clog2(PAIRS+1)-1:0]    pair_count
);
	import sit_pkg::*;

	localparam int IDX_W = $clog2(PAIRS);
	localparam int CNT_W = $clog2(PAIRS + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_DIV, ST_EVICT, ST_SHIFT, ST_OUT
	} state_t;

	state_t state_q;

	// pair store, read combinationally at the scan index or its neighbor
	logic [KEY_W-1:0]        key_q  [PAIRS];
	logic signed [FAC_W-1:0] fac_q  [PAIRS];
	logic [CNT_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        evict_q;
	logic [CNT_W-1:0]        idx_q;   // scan / shift position
	logic [KEY_W-1:0]        key_in_q;
	logic signed [FAC_W-1:0] fac_in_q;
	logic [KEY_W-1:0]        k0_q;
	logic signed [FAC_W-1:0] f0_q;
	div_req_t                div_req;
	logic                    div_done;
	logic signed [PROD_W-1:0] div_quot;

	// two read ports, at idx and idx-1
	logic [IDX_W-1:0]        ra;
	logic [IDX_W-1:0]        rb;
	logic [KEY_W-1:0]        key_a;
	logic signed [FAC_W-1:0] fac_a;
	logic [KEY_W-1:0]        key_b;
	logic signed [FAC_W-1:0] fac_b;
	logic signed [DIFF_W-1:0] fdiff;
	logic [KEY_W-1:0]        kdiff;
	logic signed [PROD_W-1:0] prod;

	assign ra = idx_q[IDX_W-1:0];
	assign rb = IDX_W'(idx_q - 1'b1);
	assign key_a = key_q[ra];
	assign fac_a = fac_q[ra];
	assign key_b = key_q[rb];
	assign fac_b = fac_q[rb];

	// interpolation terms for the bracket at (idx-1, idx)
	assign fdiff = DIFF_W'(fac_a) - DIFF_W'(fac_b);
	assign kdiff = key_in_q - key_b;
	assign prod = $signed({1'b0, kdiff}) * fdiff;

	sit_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.done  (div_done),
		.quot  (div_quot)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign pair_count = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			cnt_q <= '0;
			evict_q <= '0;
			div_req.start <= 1'b0;
		end else begin
			div_req.start <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_in_q <= speed_key;
						fac_in_q <= factor_in;
						factor_out <= '0;
						idx_q <= '0;
						unique case (op_t'(op))
							OP_LOOKUP: state_q <= ST_SCAN;
							OP_INSERT: begin
								if (cnt_q == CNT_W'(PAIRS)) begin
									// wrap slot, then shift down from it
									idx_q <= CNT_W'(evict_q);
									state_q <= ST_EVICT;
								end else begin
									idx_q <= cnt_q;
									state_q <= ST_SHIFT;
								end
							end
							OP_CLEAR: begin
								cnt_q <= '0;
								evict_q <= '0;
								out_valid <= 1'b1;
								state_q <= ST_OUT;
							end
							default: begin
								out_valid <= 1'b1;
								state_q <= ST_OUT;
							end
						endcase
					end
				end
				ST_SCAN: begin
					// stop at first key not below the query
					if (cnt_q == '0) begin
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end else if (idx_q == cnt_q) begin
						factor_out <= fac_b;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end else if (key_a < key_in_q) begin
						idx_q <= idx_q + 1'b1;
					end else if (idx_q == '0 || key_b == key_a) begin
						factor_out <= (idx_q == '0) ? fac_a : fac_b;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						f0_q <= fac_b;
						div_req.start <= 1'b1;
						div_req.neg <= prod[PROD_W-1];
						div_req.num <= prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
						div_req.den <= key_a - key_b;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						factor_out <= FAC_W'(PROD_W'(f0_q) + div_quot);
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_EVICT: begin
					// move pairs down over the evicted slot
					if (idx_q + 1'b1 < cnt_q) begin
						key_q[ra] <= key_q[IDX_W'(idx_q + 1'b1)];
						fac_q[ra] <= fac_q[IDX_W'(idx_q + 1'b1)];
						idx_q <= idx_q + 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
						idx_q <= cnt_q - 1'b1;
						evict_q <= (evict_q == IDX_W'(PAIRS - 1)) ? '0 : evict_q + 1'b1;
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					// open a gap by moving larger keys up
					if (idx_q != '0 && key_in_q < key_b) begin
						key_q[ra] <= key_b;
						fac_q[ra] <= fac_b;
						idx_q <= idx_q - 1'b1;
					end else begin
						key_q[ra] <= key_in_q;
						fac_q[ra] <= fac_in_q;
						cnt_q <= cnt_q + 1'b1;
						out_valid <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// the eviction slot advances only when the table is full and wraps after
	// PAIRS - 1, so evict_q below PAIRS always holds
	logic unused_ok;
	assign unused_ok = (evict_q <= IDX_W'(PAIRS - 1));

	`SIT_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= CNT_W'(PAIRS), "count over depth")
	`SIT_ASSERT_IMP(a_slot_range, clk, arst_n, 1'b1, unused_ok, "eviction slot out of range")
	`SIT_ASSERT_IMP(a_busy_stall, clk, arst_n, out_valid, in_stall, "input open while result held")
	`SIT_ASSERT_NXT(a_div_done, clk, arst_n, div_done && state_q == ST_DIV, out_valid, "divide result lost")
endmodule
`default_nettype wire
